FILE: rtl/core/mck_pkg.sv
// Shared types, constants and the character code table for the Morse keyer.
`default_nettype none
package mck_pkg;

  localparam int unsigned UNIT_TICKS_W     = 16;
  localparam int unsigned DURATION_W       = 19;
  localparam int unsigned PAT_W            = 7;
  localparam int unsigned LEN_W            = 3;
  localparam logic [UNIT_TICKS_W-1:0] UNIT_TICKS_RESET = 16'd200;
  localparam int unsigned FIFO_DEPTH       = 4;

  localparam logic KIND_LETTER   = 1'b0;
  localparam logic KIND_WORD_END = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic                  key_on;
    logic [DURATION_W-1:0] duration;
    logic                  last;
  } out_word_t;

  // Pattern is left aligned: symbol 0 at bit PAT_W-1, 1 = dash.
  typedef struct packed {
    logic             known;
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] pat;
  } code_t;

  // Queue entry between front and back.
  typedef struct packed {
    logic             word_end;
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] pat;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  function automatic code_t code_lookup(input logic [7:0] ch);
    code_t c;
    c = '{known: 1'b1, len: 3'd0, pat: 7'b0};
    case (ch)
      8'h41: begin c.len = 3'd2; c.pat = 7'b0100000; end // A
      8'h42: begin c.len = 3'd4; c.pat = 7'b1000000; end // B
      8'h43: begin c.len = 3'd4; c.pat = 7'b1010000; end // C
      8'h44: begin c.len = 3'd3; c.pat = 7'b1000000; end // D
      8'h45: begin c.len = 3'd1; c.pat = 7'b0000000; end // E
      8'h46: begin c.len = 3'd4; c.pat = 7'b0010000; end // F
      8'h47: begin c.len = 3'd3; c.pat = 7'b1100000; end // G
      8'h48: begin c.len = 3'd4; c.pat = 7'b0000000; end // H
      8'h49: begin c.len = 3'd2; c.pat = 7'b0000000; end // I
      8'h4A: begin c.len = 3'd4; c.pat = 7'b0111000; end // J
      8'h4B: begin c.len = 3'd3; c.pat = 7'b1010000; end // K
      8'h4C: begin c.len = 3'd4; c.pat = 7'b0100000; end // L
      8'h4D: begin c.len = 3'd2; c.pat = 7'b1100000; end // M
      8'h4E: begin c.len = 3'd2; c.pat = 7'b1000000; end // N
      8'h4F: begin c.len = 3'd3; c.pat = 7'b1110000; end // O
      8'h50: begin c.len = 3'd4; c.pat = 7'b0110000; end // P
      8'h51: begin c.len = 3'd4; c.pat = 7'b1101000; end // Q
      8'h52: begin c.len = 3'd3; c.pat = 7'b0100000; end // R
      8'h53: begin c.len = 3'd3; c.pat = 7'b0000000; end // S
      8'h54: begin c.len = 3'd1; c.pat = 7'b1000000; end // T
      8'h55: begin c.len = 3'd3; c.pat = 7'b0010000; end // U
      8'h56: begin c.len = 3'd4; c.pat = 7'b0001000; end // V
      8'h57: begin c.len = 3'd3; c.pat = 7'b0110000; end // W
      8'h58: begin c.len = 3'd4; c.pat = 7'b1001000; end // X
      8'h59: begin c.len = 3'd4; c.pat = 7'b1011000; end // Y
      8'h5A: begin c.len = 3'd4; c.pat = 7'b1100000; end // Z
      8'h30: begin c.len = 3'd5; c.pat = 7'b1111100; end // 0
      8'h31: begin c.len = 3'd5; c.pat = 7'b0111100; end // 1
      8'h32: begin c.len = 3'd5; c.pat = 7'b0011100; end // 2
      8'h33: begin c.len = 3'd5; c.pat = 7'b0001100; end // 3
      8'h34: begin c.len = 3'd5; c.pat = 7'b0000100; end // 4
      8'h35: begin c.len = 3'd5; c.pat = 7'b0000000; end // 5
      8'h36: begin c.len = 3'd5; c.pat = 7'b1000000; end // 6
      8'h37: begin c.len = 3'd5; c.pat = 7'b1100000; end // 7
      8'h38: begin c.len = 3'd5; c.pat = 7'b1110000; end // 8
      8'h39: begin c.len = 3'd5; c.pat = 7'b1111000; end // 9
      8'h2E: begin c.len = 3'd6; c.pat = 7'b0101010; end // period
      8'h2C: begin c.len = 3'd6; c.pat = 7'b1100110; end // comma
      8'h3F: begin c.len = 3'd6; c.pat = 7'b0011000; end // question mark
      8'h27: begin c.len = 3'd6; c.pat = 7'b0111100; end // apostrophe
      8'h21: begin c.len = 3'd6; c.pat = 7'b1010110; end // exclamation
      8'h2F: begin c.len = 3'd5; c.pat = 7'b1001000; end // slash
      8'h28: begin c.len = 3'd5; c.pat = 7'b1011000; end // open paren
      8'h29: begin c.len = 3'd6; c.pat = 7'b1011010; end // close paren
      8'h26: begin c.len = 3'd5; c.pat = 7'b0100000; end // ampersand
      8'h3A: begin c.len = 3'd6; c.pat = 7'b1110000; end // colon
      8'h3B: begin c.len = 3'd6; c.pat = 7'b1010100; end // semicolon
      8'h3D: begin c.len = 3'd5; c.pat = 7'b1000100; end // equals
      8'h2B: begin c.len = 3'd5; c.pat = 7'b0101000; end // plus
      8'h2D: begin c.len = 3'd6; c.pat = 7'b1000010; end // hyphen
      8'h5F: begin c.len = 3'd6; c.pat = 7'b0011010; end // underscore
      8'h22: begin c.len = 3'd6; c.pat = 7'b0100100; end // double quote
      8'h24: begin c.len = 3'd7; c.pat = 7'b0001001; end // dollar
      8'h40: begin c.len = 3'd6; c.pat = 7'b0110100; end // at sign
      default: c.known = 1'b0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/mck_front.sv
// Front end: takes input words, looks up the code, queues known jobs.
`default_nettype none
module mck_front (
  input  wire                     in_valid_i,
  output logic                    in_stall_o,
  input  mck_pkg::in_word_t       in_word_i,
  input  mck_pkg::fifo_status_t   fifo_status_i,
  output logic                    push_o,
  output mck_pkg::job_t           push_job_o
);

  mck_pkg::code_t code;
  logic           accept;

  assign code       = mck_pkg::code_lookup(in_word_i.char_code);
  assign in_stall_o = fifo_status_i.full;
  assign accept     = in_valid_i && !fifo_status_i.full;

  // Unknown characters are consumed and dropped here.
  assign push_o = accept && ((in_word_i.kind == mck_pkg::KIND_WORD_END) || code.known);

  always_comb begin
    push_job_o.word_end = (in_word_i.kind == mck_pkg::KIND_WORD_END);
    push_job_o.len      = code.len;
    push_job_o.pat      = code.pat;
  end

endmodule
`default_nettype wire

FILE: rtl/core/mck_fifo.sv
// Short job queue between the front end and the segment sequencer.
`default_nettype none
module mck_fifo #(
  parameter int unsigned Depth = mck_pkg::FIFO_DEPTH
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_i,
  input  mck_pkg::job_t           push_job_i,
  input  wire                     pop_i,
  output mck_pkg::job_t           head_o,
  output mck_pkg::fifo_status_t   status_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  mck_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntFull);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/mck_back.sv
// Back end: walks the head job symbol by symbol into registered segments.
`default_nettype none
module mck_back (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire [mck_pkg::UNIT_TICKS_W-1:0] unit_ticks_i,
  input  mck_pkg::job_t                 head_i,
  input  mck_pkg::fifo_status_t         fifo_status_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output mck_pkg::out_word_t            out_word_o
);

  localparam int unsigned DW = mck_pkg::DURATION_W;

  typedef enum logic [2:0] {
    ST_MARK  = 3'b001,
    ST_SPACE = 3'b010,
    ST_CLOSE = 3'b100
  } seg_state_e;

  seg_state_e state_q, state_d;
  logic [mck_pkg::LEN_W-1:0] idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  mck_pkg::out_word_t        out_word_q, out_word_d;

  logic          can_load;
  logic          fire;
  logic [DW-1:0] dur1, dur3, dur7;
  logic [mck_pkg::LEN_W-1:0] bit_sel;

  // Constant multiples by shift and add or subtract.
  assign dur1 = DW'(unit_ticks_i);
  assign dur3 = DW'({unit_ticks_i, 1'b0}) + dur1;
  assign dur7 = DW'({unit_ticks_i, 3'b000}) - dur1;

  assign bit_sel  = mck_pkg::LEN_W'(mck_pkg::PAT_W - 1) - idx_q;
  assign can_load = !out_valid_q || !out_stall_i;
  assign fire     = can_load && !fifo_status_i.empty;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (can_load) begin
      out_valid_d = fire;
    end
    if (fire) begin
      if (head_i.word_end) begin
        out_word_d = '{key_on: 1'b0, duration: dur7, last: 1'b1};
        pop_o      = 1'b1;
      end else begin
        case (state_q)
          ST_MARK: begin
            out_word_d = '{key_on: 1'b1,
                           duration: head_i.pat[bit_sel] ? dur3 : dur1,
                           last: 1'b0};
            state_d = ST_SPACE;
          end
          ST_SPACE: begin
            out_word_d = '{key_on: 1'b0, duration: dur1, last: 1'b0};
            if (idx_q == head_i.len - 1'b1) begin
              state_d = ST_CLOSE;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = ST_MARK;
            end
          end
          ST_CLOSE: begin
            out_word_d = '{key_on: 1'b0, duration: dur3, last: 1'b1};
            pop_o      = 1'b1;
            idx_d      = '0;
            state_d    = ST_MARK;
          end
          default: begin
            state_d = ST_MARK;
            idx_d   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_MARK;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire

FILE: rtl/core/morse_code_keyer.sv
// Top level of the Morse keyer: config register, front end, job queue, back end.
`default_nettype none
// Each input word is a letter (looked up in a 54-entry ITU table) or a word
// end. A letter of n symbols comes out as 2n+1 segments (mark, space per
// symbol, then a 3-unit letter gap marked last); a word end is one 7-unit
// off segment; unknown characters are consumed with no output. The segment
// sequencer emits one segment per cycle while the queue holds a job and the
// output is not stalled. A queue of FifoDepth jobs lets new words enter while
// earlier ones are still being keyed; the input stalls only when that queue is
// full. unit_ticks may be written only while the block is idle; durations are
// units times unit_ticks, 19 bits.
module morse_code_keyer #(
  parameter int unsigned FifoDepth = mck_pkg::FIFO_DEPTH
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [mck_pkg::UNIT_TICKS_W-1:0] cfg_data_i,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  mck_pkg::in_word_t               in_word_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output mck_pkg::out_word_t              out_word_o
);

  logic [mck_pkg::UNIT_TICKS_W-1:0] unit_ticks_q;
  mck_pkg::fifo_status_t fifo_status;
  mck_pkg::job_t         push_job, head_job;
  logic                  push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_ticks_q <= mck_pkg::UNIT_TICKS_RESET;
    end else if (cfg_we_i) begin
      unit_ticks_q <= cfg_data_i;
    end
  end

  mck_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_word_i     (in_word_i),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .push_job_o    (push_job)
  );

  mck_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .status_o   (fifo_status)
  );

  mck_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .unit_ticks_i  (unit_ticks_q),
    .head_i        (head_job),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_o    (out_word_o)
  );

endmodule
`default_nettype wire

FILE: dv/morse_code_keyer_test.sv
// Self-checking testbench for morse_code_keyer: directed letters, unit lengths, random traffic, backpressure.
`default_nettype none
module morse_code_keyer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mck_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_WORDS    = 44;
  localparam int unsigned LETTER_GAP     = 3;
  localparam int unsigned WORD_GAP       = 7;
  localparam string       KNOWN_CHARS    =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?'!/()&:;=+-_\"$@";

  typedef enum int unsigned {RX_READY, RX_COIN, RX_PERIODIC, RX_HEAVY} rx_mode_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [UNIT_TICKS_W-1:0] cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  in_word_t                in_word_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  out_word_t               out_word_o;

  logic [UNIT_TICKS_W-1:0] unit_ticks;
  out_word_t               expected_segments[$];
  int unsigned             fail_count;
  int unsigned             hold_request;
  int unsigned             letters_sent, word_ends_sent, unknown_sent;
  int unsigned             segments_checked, unit_settings, input_stall_cycles;

  morse_code_keyer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ITU dot/dash string for a character, empty when not in the table
  function automatic string morse_code_of(input logic [7:0] ch);
    case (ch)
      "A": return ".-";      "B": return "-...";    "C": return "-.-.";
      "D": return "-..";     "E": return ".";       "F": return "..-.";
      "G": return "--.";     "H": return "....";    "I": return "..";
      "J": return ".---";    "K": return "-.-";     "L": return ".-..";
      "M": return "--";      "N": return "-.";      "O": return "---";
      "P": return ".--.";    "Q": return "--.-";    "R": return ".-.";
      "S": return "...";     "T": return "-";       "U": return "..-";
      "V": return "...-";    "W": return ".--";     "X": return "-..-";
      "Y": return "-.--";    "Z": return "--..";
      "0": return "-----";   "1": return ".----";   "2": return "..---";
      "3": return "...--";   "4": return "....-";   "5": return ".....";
      "6": return "-....";   "7": return "--...";   "8": return "---..";
      "9": return "----.";
      ".": return ".-.-.-";  ",": return "--..--";  "?": return "..--..";
      "'": return ".----.";  "!": return "-.-.--";  "/": return "-..-.";
      "(": return "-.--.";   ")": return "-.--.-";  "&": return ".-...";
      ":": return "---...";  ";": return "-.-.-.";  "=": return "-...-";
      "+": return ".-.-.";   "-": return "-....-";  "_": return "..--.-";
      "\"": return ".-..-."; "$": return "...-..-"; "@": return ".--.-.";
      default: return "";
    endcase
  endfunction

  function automatic void queue_segment(input logic on, input int unsigned units,
                                        input logic closing);
    out_word_t seg;
    seg.key_on   = on;
    seg.duration = DURATION_W'(units * unit_ticks);
    seg.last     = closing;
    expected_segments.push_back(seg);
  endfunction

  function automatic void predict_segments(input in_word_t w);
    string code;
    if (w.kind == KIND_WORD_END) begin
      queue_segment(1'b0, WORD_GAP, 1'b1);
      word_ends_sent++;
      return;
    end
    code = morse_code_of(w.char_code);
    if (code.len() == 0) begin
      unknown_sent++;
      return;
    end
    for (int i = 0; i < code.len(); i++) begin
      queue_segment(1'b1, (code[i] == "-") ? 3 : 1, 1'b0);
      queue_segment(1'b0, 1, 1'b0);
    end
    queue_segment(1'b0, LETTER_GAP, 1'b1);
    letters_sent++;
  endfunction

  function automatic in_word_t word_of(input logic kind, input logic [7:0] ch);
    in_word_t w;
    w.kind      = kind;
    w.char_code = ch;
    return w;
  endfunction

  function automatic in_word_t random_word();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70)
      return word_of(KIND_LETTER, KNOWN_CHARS[$urandom_range(0, KNOWN_CHARS.len() - 1)]);
    else if (pick < 85)
      return word_of(KIND_WORD_END, 8'($urandom));
    else
      return word_of(KIND_LETTER, 8'($urandom));
  endfunction

  // offer one word, hold it until taken, then, when gap is nonzero, drop valid before returning
  task automatic push_word(input in_word_t w, input int unsigned gap);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    predict_segments(w);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk_i);
    // unknown codes leave no trace at the output, give them time to retire
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_unit(input logic [UNIT_TICKS_W-1:0] ticks);
    drain_pipeline();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= ticks;
    @(posedge clk_i);
    unit_ticks = ticks;
    unit_settings++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_default_unit();
    push_word(word_of(KIND_LETTER, "E"), 0);
    push_word(word_of(KIND_LETTER, "T"), 1);
    push_word(word_of(KIND_LETTER, "$"), 0);      // seven symbols, fifteen segments
    push_word(word_of(KIND_WORD_END, 8'hFF), 2);
    push_word(word_of(KIND_WORD_END, "E"), 0);    // char ignored on word end
    push_word(word_of(KIND_LETTER, 8'h00), 0);
    push_word(word_of(KIND_LETTER, "a"), 1);
    push_word(word_of(KIND_LETTER, "z"), 0);
    push_word(word_of(KIND_LETTER, 8'hFF), 0);
    push_word(word_of(KIND_LETTER, "5"), 1);
  endtask

  task automatic test_unit_extremes();
    program_unit(16'hFFFF);
    push_word(word_of(KIND_LETTER, "0"), 0);
    push_word(word_of(KIND_WORD_END, 8'h00), 0);
    push_word(word_of(KIND_LETTER, "@"), 1);
    program_unit(16'd1);
    push_word(word_of(KIND_LETTER, "H"), 0);
    push_word(word_of(KIND_WORD_END, 8'h55), 1);
    program_unit(16'd0);                          // zero unit gives zero durations
    push_word(word_of(KIND_LETTER, "A"), 0);
    push_word(word_of(KIND_WORD_END, 8'hAA), 1);
  endtask

  task automatic test_random_traffic();
    logic [UNIT_TICKS_W-1:0] settings[5];
    int unsigned burst_left, gap, useful;
    in_word_t w;
    settings = '{16'($urandom_range(2, 65534)), 16'hFFFF, 16'd1, UNIT_TICKS_RESET,
                 16'($urandom_range(2, 1000))};
    foreach (settings[s]) begin
      program_unit(settings[s]);
      useful = 0;
      burst_left = $urandom_range(1, 20);
      while (useful < PHASE_WORDS) begin
        w = random_word();
        if (w.kind == KIND_WORD_END || morse_code_of(w.char_code).len() != 0) useful++;
        burst_left--;
        gap = 0;
        if (burst_left == 0) begin
          gap = $urandom_range(1, 12);
          burst_left = $urandom_range(1, 20);
        end
        push_word(w, gap);
      end
    end
  endtask

  task automatic test_backpressure();
    drain_pipeline();
    @(posedge clk_i);
    hold_request = HOLD_CYCLES;
    repeat (24) push_word(word_of(KIND_LETTER, ($urandom_range(0, 1) != 0) ? "$" : "0"), 0);
    push_word(word_of(KIND_WORD_END, 8'($urandom)), 1);
  endtask

  // receiver: random stall pattern, plus a long hold-off on request
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left, hold_left, phase;
    logic        stall;
    out_stall_i = 1'b0;
    mode_left = 0;
    hold_left = 0;
    phase = 0;
    mode = RX_READY;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      phase++;
      if (hold_left != 0) begin
        hold_left--;
        stall = 1'b1;
      end else begin
        case (mode)
          RX_READY:    stall = 1'b0;
          RX_COIN:     stall = 1'($urandom_range(0, 1));
          RX_PERIODIC: stall = (phase % 4) == 3;
          default:     stall = $urandom_range(0, 9) < 8;
        endcase
      end
      out_stall_i <= stall;
    end
  end

  always @(posedge clk_i) begin : check_segments
    out_word_t want;
    if (rst_ni && in_valid_i && in_stall_o) input_stall_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_segments.size() == 0) begin
        $display("%0t: unexpected segment, expected none, actual %p", $time, out_word_o);
        fail_count++;
      end else begin
        want = expected_segments.pop_front();
        segments_checked++;
        if (out_word_o.key_on !== want.key_on) begin
          $display("%0t: key_on expected %0d actual %0d", $time, want.key_on,
                   out_word_o.key_on);
          fail_count++;
        end
        if (out_word_o.duration !== want.duration) begin
          $display("%0t: duration expected %0d actual %0d", $time, want.duration,
                   out_word_o.duration);
          fail_count++;
        end
        if (out_word_o.last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last,
                   out_word_o.last);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d segments outstanding", $time,
                 quiet, expected_segments.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    unit_ticks = UNIT_TICKS_RESET;
    fail_count = 0;
    hold_request = 0;
    letters_sent = 0;
    word_ends_sent = 0;
    unknown_sent = 0;
    segments_checked = 0;
    unit_settings = 1;
    input_stall_cycles = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_unit();
    test_unit_extremes();
    test_random_traffic();
    test_backpressure();
    drain_pipeline();

    if (expected_segments.size() != 0) begin
      $display("%0t: %0d expected segments never arrived", $time, expected_segments.size());
      fail_count++;
    end
    $display("Keyed %0d letters, %0d word ends and %0d unknown codes over %0d unit lengths.",
             letters_sent, word_ends_sent, unknown_sent, unit_settings);
    $display("Checked %0d segments; input was held back for %0d cycles.", segments_checked,
             input_stall_cycles);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: morse_code_keyer.f
rtl/core/mck_pkg.sv
rtl/core/mck_front.sv
rtl/core/mck_fifo.sv
rtl/core/mck_back.sv
rtl/core/morse_code_keyer.sv
dv/morse_code_keyer_test.sv
